/* design/fc_pkg.sv */
// ----------------------------------------------------------------------------
// Frustum cull package
// Shared widths, item types, kind codes and the value conversion used by the
// frustum culling pipeline and its channel interfaces.
// ----------------------------------------------------------------------------
package fc_pkg;

  // Width that matrix elements and coordinates are kept at.
  localparam int DATA_WIDTH = 32;
  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;
  localparam int FRAC_BITS  = 16;
  localparam int IN_WIDTH   = 32;

  // Plane coefficient, product and sum widths. All arithmetic is exact.
  localparam int COEF_WIDTH = DATA_WIDTH + 1;
  localparam int PROD_WIDTH = COEF_WIDTH + DATA_WIDTH;
  localparam int SUM_WIDTH  = PROD_WIDTH + 2;

  // Item kinds.
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_BOX   = 2'd2;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic signed [SUM_WIDTH-1:0]  sum_t;

  typedef struct packed {
    logic        [1:0]          kind;
    logic        [1:0]          elem_row;
    logic        [1:0]          elem_col;
    logic signed [IN_WIDTH-1:0] elem_value;
    logic signed [IN_WIDTH-1:0] px;
    logic signed [IN_WIDTH-1:0] py;
    logic signed [IN_WIDTH-1:0] pz;
    logic signed [IN_WIDTH-1:0] qx;
    logic signed [IN_WIDTH-1:0] qy;
    logic signed [IN_WIDTH-1:0] qz;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
  } out_item_t;

  // Brings a 32-bit two's complement input value to the internal width:
  // truncated when narrower, sign-extended when wider.
  function automatic data_t to_data(logic signed [IN_WIDTH-1:0] x);
    return data_t'(x);
  endfunction

endpackage

/* design/fc_if.sv */
// ----------------------------------------------------------------------------
// Frustum cull channel interfaces
// Valid/ready channels for test items and results.
// ----------------------------------------------------------------------------
interface fc_in_if;
  import fc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface fc_out_if;
  import fc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* design/frustum_cull_test.sv */
// ----------------------------------------------------------------------------
// Frustum cull test
// Holds a 4x4 view-projection matrix, derives the six frustum planes from it
// and tests points and axis-aligned boxes against them in a pipeline.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Content                          Transaction
//   in_if    sink       kind, element load, point/box    valid && ready
//   out_if   source     inside_res                       valid && ready
//
// One transaction is accepted per clock cycle when the pipeline is not
// blocked. The four register stages are plane coefficients, multipliers,
// pair sums, and final sum and sign. A point or box test passes through
// them in that order and is presented on the output from the last one.
// Matrix loads give no result and are seen by the very next test.
// Reset clears the matrix and all valid bits. A stall at the output holds
// each full stage whose later stages are all full; any stage keeps moving
// while the one after it is empty, so bubbles are squeezed out.
//
module frustum_cull_test (
  input  logic      clk,
  input  logic      rst_n,
  fc_in_if.sink     in_if,
  fc_out_if.source  out_if
);
  import fc_pkg::*;

  // Matrix store and stage registers.
  data_t matrix_r [4][4];

  logic  s1_valid_r;
  logic  s1_box_r;
  coef_t s1_coef_r [NUM_PLANES][4];
  data_t s1_lo_r   [NUM_AXES];
  data_t s1_hi_r   [NUM_AXES];

  logic  s2_valid_r;
  prod_t s2_prod_r [NUM_PLANES][NUM_AXES];
  sum_t  s2_d_r    [NUM_PLANES];

  logic  s3_valid_r;
  sum_t  s3_sa_r   [NUM_PLANES];
  sum_t  s3_sb_r   [NUM_PLANES];

  logic  out_valid_r;
  logic  out_inside_r;

  // Stage advance signals.
  logic out_rdy;
  logic s3_rdy;
  logic s2_rdy;
  logic s1_rdy;
  logic in_fire;
  logic is_test;

  assign out_rdy = !out_valid_r || out_if.ready;
  assign s3_rdy  = !s3_valid_r || out_rdy;
  assign s2_rdy  = !s2_valid_r || s3_rdy;
  assign s1_rdy  = !s1_valid_r || s2_rdy;

  assign in_if.ready = s1_rdy;
  assign in_fire     = in_if.valid && s1_rdy;
  assign is_test     = (in_if.data.kind == KIND_POINT) || (in_if.data.kind == KIND_BOX);

  assign out_if.valid           = out_valid_r;
  assign out_if.data.inside_res = out_inside_r;

  // Matrix element load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          matrix_r[r][c] <= '0;
        end
      end
    end else if (in_fire && in_if.data.kind == KIND_LOAD) begin
      matrix_r[in_if.data.elem_row][in_if.data.elem_col] <= to_data(in_if.data.elem_value);
    end
  end

  // Stage 1: plane coefficients from the matrix, corners captured.
  coef_t s1_coef_nxt [NUM_PLANES][4];
  data_t s1_lo_nxt   [NUM_AXES];
  data_t s1_hi_nxt   [NUM_AXES];

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int i = 0; i < 4; i++) begin
        if (p % 2 == 1) begin
          s1_coef_nxt[p][i] = coef_t'(matrix_r[i][3]) - coef_t'(matrix_r[i][p / 2]);
        end else begin
          s1_coef_nxt[p][i] = coef_t'(matrix_r[i][3]) + coef_t'(matrix_r[i][p / 2]);
        end
      end
    end
    s1_lo_nxt[0] = to_data(in_if.data.px);
    s1_lo_nxt[1] = to_data(in_if.data.py);
    s1_lo_nxt[2] = to_data(in_if.data.pz);
    s1_hi_nxt[0] = to_data(in_if.data.qx);
    s1_hi_nxt[1] = to_data(in_if.data.qy);
    s1_hi_nxt[2] = to_data(in_if.data.qz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_valid_r <= in_fire && is_test;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_fire) begin
      s1_box_r  <= (in_if.data.kind == KIND_BOX);
      s1_coef_r <= s1_coef_nxt;
      s1_lo_r   <= s1_lo_nxt;
      s1_hi_r   <= s1_hi_nxt;
    end
  end

  // Stage 2: corner selection by coefficient sign and the plane products.
  prod_t s2_prod_nxt [NUM_PLANES][NUM_AXES];
  sum_t  s2_d_nxt    [NUM_PLANES];
  data_t pick;

  always_comb begin
    pick = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        // A box takes its maximum only where the coefficient is positive.
        if (s1_box_r && !s1_coef_r[p][a][COEF_WIDTH-1] && (s1_coef_r[p][a] != '0)) begin
          pick = s1_hi_r[a];
        end else begin
          pick = s1_lo_r[a];
        end
        s2_prod_nxt[p][a] = prod_t'(s1_coef_r[p][a]) * prod_t'(pick);
      end
      s2_d_nxt[p] = sum_t'(s1_coef_r[p][3]) <<< FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_valid_r) begin
      s2_prod_r <= s2_prod_nxt;
      s2_d_r    <= s2_d_nxt;
    end
  end

  // Stage 3: pairwise sums of the four plane terms.
  sum_t s3_sa_nxt [NUM_PLANES];
  sum_t s3_sb_nxt [NUM_PLANES];

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      s3_sa_nxt[p] = sum_t'(s2_prod_r[p][0]) + sum_t'(s2_prod_r[p][1]);
      s3_sb_nxt[p] = sum_t'(s2_prod_r[p][2]) + s2_d_r[p];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_valid_r) begin
      s3_sa_r <= s3_sa_nxt;
      s3_sb_r <= s3_sb_nxt;
    end
  end

  // Stage 4: final sum, sign per plane, and all six planes combined.
  logic [NUM_PLANES-1:0] plane_ok;
  sum_t                  total;
  logic                  out_inside_nxt;

  always_comb begin
    total = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      total       = s3_sa_r[p] + s3_sb_r[p];
      plane_ok[p] = !total[SUM_WIDTH-1];
    end
    out_inside_nxt = &plane_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && s3_valid_r) begin
      out_inside_r <= out_inside_nxt;
    end
  end

  // Only point and box tests enter the pipeline.
  a_test_only_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (s1_valid_r == $past(is_test)))
    else $error("stage 1 valid does not follow the kind of the accepted item");

  // A blocked stage 3 keeps its item and its plane 0 sums.
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && !out_rdy) |=> (s3_valid_r && $stable(s3_sa_r[0]) && $stable(s3_sb_r[0])))
    else $error("stage 3 item changed while blocked");

  // A loaded element lands in the addressed matrix entry.
  a_load_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_if.data.kind == KIND_LOAD) |=>
      (matrix_r[$past(in_if.data.elem_row)][$past(in_if.data.elem_col)]
        == to_data($past(in_if.data.elem_value))))
    else $error("matrix load not stored");

  // The output register only fills from a valid stage 3 item.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r)) |-> $past(s3_valid_r))
    else $error("result appeared without a stage 3 item");

endmodule

/* tb/frustum_cull_test_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frustum cull testbench
// Loads view-projection matrices into the culling block and streams point
// and box tests through it under random and directed flow control. Each
// accepted test is scored against an exact in-bench plane evaluation, and
// the inside flags that come back are checked in order.
// ----------------------------------------------------------------------------
module frustum_cull_test_test;
  import fc_pkg::*;

  // Unused kind code; the block drops such transactions.
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  localparam logic signed [IN_WIDTH-1:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [IN_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [IN_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  localparam int LONG_STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES      = 20;

  logic clk = 1'b0;
  logic rst_n;

  fc_in_if  in_ch();
  fc_out_if out_ch();

  frustum_cull_test dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #5 clk = ~clk;

  // Pending stimulus, expected inside flags and the bench copy of the matrix.
  in_item_t pending_items[$];
  logic     expected_inside[$];
  data_t    view_proj[16];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  bit stall_req = 1'b0;
  int stall_left = 0;

  // Evaluates all six planes exactly and reports whether the item passes.
  function automatic logic frustum_contains(in_item_t it);
    data_t               lo[3];
    data_t               hi[3];
    data_t               pt[3];
    coef_t               co[4];
    coef_t               base;
    coef_t               axis_val;
    logic signed [127:0] acc;
    logic signed [127:0] cw;
    logic signed [127:0] pw;
    logic                pass;
    int                  axis;
    lo[0] = data_t'(it.px);
    lo[1] = data_t'(it.py);
    lo[2] = data_t'(it.pz);
    hi[0] = data_t'(it.qx);
    hi[1] = data_t'(it.qy);
    hi[2] = data_t'(it.qz);
    pass = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      axis = p / 2;
      for (int i = 0; i < 4; i++) begin
        base     = coef_t'(view_proj[i * 4 + 3]);
        axis_val = coef_t'(view_proj[i * 4 + axis]);
        co[i] = (p % 2 == 1) ? base - axis_val : base + axis_val;
      end
      // Box tests take the corner that lies furthest along the plane normal.
      for (int i = 0; i < NUM_AXES; i++) begin
        if (it.kind == KIND_POINT) pt[i] = lo[i];
        else pt[i] = (co[i] > 0) ? hi[i] : lo[i];
      end
      acc = 128'(co[3]);
      acc = acc <<< FRAC_BITS;
      for (int i = 0; i < NUM_AXES; i++) begin
        cw = 128'(co[i]);
        pw = 128'(pt[i]);
        acc = acc + cw * pw;
      end
      if (acc < 0) pass = 1'b0;
    end
    return pass;
  endfunction

  // Driver: scores each accepted transaction, then offers the next item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      for (int i = 0; i < 16; i++) view_proj[i] = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.data.kind)
          KIND_LOAD: begin
            view_proj[{in_ch.data.elem_row, in_ch.data.elem_col}] =
              data_t'(in_ch.data.elem_value);
          end
          KIND_POINT, KIND_BOX: begin
            expected_inside.push_back(frustum_contains(in_ch.data));
          end
          default: begin
          end
        endcase
      end
      if (in_ch.valid && !in_ch.ready) begin
        in_ch.valid <= 1'b1;
      end else if (pending_items.size() != 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= pending_items.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transaction and drives the output ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_inside.size() == 0) begin
          $error("inside_res: no result expected, actual %0b", out_ch.data.inside_res);
          mismatch_count++;
        end else begin
          logic exp_flag;
          exp_flag = expected_inside.pop_front();
          if (out_ch.data.inside_res !== exp_flag) begin
            $error("inside_res: expected %0b, actual %0b", exp_flag,
                   out_ch.data.inside_res);
            mismatch_count++;
          end
        end
      end
      if (stall_req) begin
        stall_req = 1'b0;
        stall_left = LONG_STALL_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Random coordinate or element value: mostly near the unit range.
  function automatic logic signed [IN_WIDTH-1:0] rand_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return IN_WIDTH'($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
    if (sel < 85) return $urandom;
    case ($urandom_range(4))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return -1;
      default: return Q_ONE;
    endcase
  endfunction

  // Item with every field random; callers then set the fields that matter.
  function automatic in_item_t random_item();
    in_item_t it;
    it.kind       = 2'($urandom_range(3));
    it.elem_row   = 2'($urandom_range(3));
    it.elem_col   = 2'($urandom_range(3));
    it.elem_value = $urandom;
    it.px         = $urandom;
    it.py         = $urandom;
    it.pz         = $urandom;
    it.qx         = $urandom;
    it.qy         = $urandom;
    it.qz         = $urandom;
    return it;
  endfunction

  task automatic queue_load(input logic [1:0] row, input logic [1:0] col,
                            input logic signed [IN_WIDTH-1:0] value);
    in_item_t it;
    it = random_item();
    it.kind       = KIND_LOAD;
    it.elem_row   = row;
    it.elem_col   = col;
    it.elem_value = value;
    pending_items.push_back(it);
  endtask

  task automatic queue_test(input logic [1:0] kind,
                            input logic signed [IN_WIDTH-1:0] x0, y0, z0,
                            input logic signed [IN_WIDTH-1:0] x1, y1, z1);
    in_item_t it;
    it = random_item();
    it.kind = kind;
    it.px = x0;
    it.py = y0;
    it.pz = z0;
    it.qx = x1;
    it.qy = y1;
    it.qz = z1;
    pending_items.push_back(it);
  endtask

  task automatic queue_ignored();
    in_item_t it;
    it = random_item();
    it.kind = KIND_IGNORED;
    pending_items.push_back(it);
  endtask

  // Loads a plausible projection: scaled diagonal, positive w, small skew.
  task automatic queue_frustum_matrix();
    logic signed [IN_WIDTH-1:0] v;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (r == c && r < 3) v = $urandom_range(32'h0002_0000, 32'h0000_4000);
        else if (r == 3 && c == 3) v = $urandom_range(32'h0008_0000, 32'h0001_0000);
        else if ($urandom_range(1) == 0) v = '0;
        else v = IN_WIDTH'($urandom_range(32'h0000_8000)) - 32'sh0000_4000;
        queue_load(r[1:0], c[1:0], v);
      end
    end
  endtask

  // Random point or box test; most boxes are well ordered.
  task automatic queue_random_test();
    logic signed [IN_WIDTH-1:0] x0, y0, z0, x1, y1, z1;
    x0 = rand_value();
    y0 = rand_value();
    z0 = rand_value();
    if ($urandom_range(99) < 70) begin
      x1 = x0 + IN_WIDTH'($urandom_range(32'h0004_0000));
      y1 = y0 + IN_WIDTH'($urandom_range(32'h0004_0000));
      z1 = z0 + IN_WIDTH'($urandom_range(32'h0004_0000));
    end else begin
      x1 = rand_value();
      y1 = rand_value();
      z1 = rand_value();
    end
    queue_test($urandom_range(1) ? KIND_BOX : KIND_POINT, x0, y0, z0, x1, y1, z1);
  endtask

  task automatic run_random(input int count);
    int n;
    int sel;
    n = 0;
    while (n < count) begin
      sel = $urandom_range(99);
      if (sel < 6) begin
        queue_frustum_matrix();
        n += 16;
      end else if (sel < 20) begin
        queue_load(2'($urandom_range(3)), 2'($urandom_range(3)), rand_value());
        n++;
      end else if (sel < 23) begin
        queue_ignored();
      end else begin
        queue_random_test();
        n++;
      end
    end
  endtask

  // Waits until every item is accepted and every result has come back.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_ch.valid || expected_inside.size() != 0)
      @(negedge clk);
  endtask

  // Stimulus sequence and end of run.
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty matrix, unit cube frustum, extremes, ignored kind.
    queue_test(KIND_POINT, '0, '0, '0, '0, '0, '0);
    queue_test(KIND_BOX, Q_ONE, Q_ONE, Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE);
    queue_ignored();
    queue_load(2'd0, 2'd0, Q_ONE);
    queue_load(2'd1, 2'd1, Q_ONE);
    queue_load(2'd2, 2'd2, Q_ONE);
    queue_load(2'd3, 2'd3, Q_ONE);
    queue_test(KIND_POINT, '0, '0, '0, '0, '0, '0);
    queue_test(KIND_POINT, Q_ONE, Q_ONE, Q_ONE, '0, '0, '0);
    queue_test(KIND_POINT, Q_ONE + 1, '0, '0, '0, '0, '0);
    queue_test(KIND_POINT, -Q_ONE, -Q_ONE, -Q_ONE, '0, '0, '0);
    queue_test(KIND_BOX, -3 * Q_ONE, -3 * Q_ONE, -3 * Q_ONE,
               -2 * Q_ONE, -2 * Q_ONE, -2 * Q_ONE);
    queue_test(KIND_BOX, Q_ONE / 2, Q_ONE / 2, Q_ONE / 2,
               5 * Q_ONE, 5 * Q_ONE, 5 * Q_ONE);
    // Inverted box: corners are taken as given.
    queue_test(KIND_BOX, 5 * Q_ONE, 5 * Q_ONE, 5 * Q_ONE,
               -5 * Q_ONE, -5 * Q_ONE, -5 * Q_ONE);
    queue_test(KIND_POINT, VAL_MIN, VAL_MIN, VAL_MIN, '0, '0, '0);
    queue_test(KIND_BOX, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX);
    queue_load(2'd0, 2'd3, VAL_MIN);
    queue_load(2'd0, 2'd0, VAL_MAX);
    queue_load(2'd3, 2'd3, VAL_MAX);
    queue_test(KIND_POINT, VAL_MAX, VAL_MIN, '0, '0, '0, '0);
    queue_test(KIND_BOX, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX);
    queue_load(2'd3, 2'd2, VAL_MIN);
    queue_test(KIND_POINT, '0, '0, '0, '0, '0, '0);
    queue_ignored();
    wait_drained();

    // Long output stall while the sender keeps offering tests.
    stall_req = 1'b1;
    repeat (40) queue_random_test();
    while (stall_req || stall_left != 0) @(negedge clk);
    wait_drained();

    send_idle_pct = 9;
    recv_idle_pct = 69;
    run_random(225);
    wait_drained();

    send_idle_pct = 69;
    recv_idle_pct = 9;
    run_random(225);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(225);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_inside.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
